// ===== rtl/gad_pkg.sv =====
// gad_pkg: shared types and constants for the gamma-aware error diffusion dither
// used by the top level, gad_err_mem and gad_quant; no dependencies
`timescale 1ns / 1ps

package gad_pkg;

	// error words: signed, 8 fraction bits, saturated at +-1023.0
	localparam int ERR_W   = 19;
	localparam int ERR_LIM = 261888;
	localparam int FULL_Q8 = 65280;
	localparam int HALF_Q8 = 32640;

	typedef logic signed [ERR_W-1:0] err_t;

	// item kinds carried in tuser
	localparam logic [1:0] ACT_PIXEL    = 2'd0;
	localparam logic [1:0] ACT_LOAD_DEC = 2'd1;
	localparam logic [1:0] ACT_LOAD_ENC = 2'd2;

	// configuration register indexes
	localparam logic REG_BITS  = 1'b0;
	localparam logic REG_WIDTH = 1'b1;

	// quantizer result handed to the sequencer
	typedef struct packed {
		logic [7:0]  level;
		logic [7:0]  recon;
		logic [15:0] q;
	} quant_res_t;

endpackage

// ===== rtl/gamma_aware_error_diffusion_dither_unit.sv =====
// gamma_aware_error_diffusion_dither_unit: top level, sequencer and error datapath
// depends on gad_pkg, gad_lut, gad_err_mem, gad_quant
//
// channel   dir  signals                              contents (low bit first)
// s_axis    in   tvalid tready tdata[15:0] tuser[2:0] pixel, table_value / action, start_of_frame
// m_axis    out  tvalid tready tdata[15:0]            pixel_out, level
// cfg       in   cfg_we cfg_addr cfg_data[10:0]       0 bits_per_level, 1 image_width
//
// a pixel passes the lookup step, the five-stage quantizer, the error step and, on the last pixel
// of a row, an extra line memory write step (the line memory has a single write port) before
// the output step loads the output register; the input is not ready again until then, and
// table loads and ignored items are taken without leaving the idle state
// arst_n clears the control state, the error state and all table valid bits at once
// the result register lets the next item in while a result waits; a pixel whose result
// cannot leave waits in the last step until m_axis_tready frees the register
`timescale 1ns / 1ps

module gamma_aware_error_diffusion_dither_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // pixel, table_value
	input  logic [2:0]  s_axis_tuser,   // action, start_of_frame
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // pixel_out, level
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [10:0] cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int FWW = $clog2(MAX_WIDTH + 1);
	localparam int LW  = (FWW > 11) ? FWW : 11;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOOK  = 3'd1;
	localparam logic [2:0] ST_QUANT = 3'd2;
	localparam logic [2:0] ST_ERR   = 3'd3;
	localparam logic [2:0] ST_LASTW = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam logic signed [21:0] LIM_P = 22'sd261888;
	localparam logic signed [21:0] LIM_N = -22'sd261888;

	function automatic gad_pkg::err_t sat_err(input logic signed [21:0] v);
		gad_pkg::err_t r;
		if (v > LIM_P) begin
			r = LIM_P[gad_pkg::ERR_W-1:0];
		end else if (v < LIM_N) begin
			r = LIM_N[gad_pkg::ERR_W-1:0];
		end else begin
			r = v[gad_pkg::ERR_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [21:0] ext(input gad_pkg::err_t e);
		return $signed({{(22 - gad_pkg::ERR_W){e[gad_pkg::ERR_W-1]}}, e});
	endfunction

	// divide by 16 rounding toward zero
	function automatic logic signed [21:0] div16(input logic signed [21:0] v);
		logic signed [21:0] a;
		a = (v < 0) ? (v + 22'sd15) : v;
		return a >>> 4;
	endfunction

	logic [2:0]          state_q;
	logic [3:0]          bits_q;
	logic [10:0]         width_q;
	logic [CW-1:0]       column_q;
	gad_pkg::err_t       right_q, bp0_q, bp1_q, inc_q, p0_q;
	logic                first_row_q;
	logic [7:0]          pix_q;
	logic [7:0]          res_po_q, res_lvl_q;
	logic                m_tvalid_q;
	logic [15:0]         m_tdata_q;

	logic                in_acc;
	logic [1:0]          act;
	logic                sof;
	logic [7:0]          dec_rdata, enc_rdata;
	gad_pkg::err_t       line_rdata;
	logic [CW-1:0]       line_raddr;
	logic                lw_we;
	logic [CW-1:0]       lw_addr;
	gad_pkg::err_t       lw_data;
	logic                q_start, q_done;
	gad_pkg::quant_res_t qres;
	logic [3:0]          bits_eff;
	logic [LW-1:0]       w_eff;
	logic                last;

	gad_pkg::err_t       inc;
	logic signed [21:0]  s_full;
	logic [15:0]         s_clamp;
	gad_pkg::err_t       err;
	logic signed [21:0]  err_x, sum_x, e3_q16, e5_q16, e7_q16, e1_q16;
	gad_pkg::err_t       wr_cm1, p0;

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign act           = s_axis_tuser[1:0];
	assign sof           = s_axis_tuser[2];

	// effective depth and row width
	always_comb begin
		if (bits_q == 4'd0) begin
			bits_eff = 4'd1;
		end else if (bits_q > 4'd8) begin
			bits_eff = 4'd8;
		end else begin
			bits_eff = bits_q;
		end
		if (width_q == 11'd0) begin
			w_eff = LW'(1);
		end else if (LW'(width_q) > LW'(MAX_WIDTH)) begin
			w_eff = LW'(MAX_WIDTH);
		end else begin
			w_eff = LW'(width_q);
		end
	end

	assign last = (LW'(column_q) + LW'(1) >= w_eff);

	gad_lut u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (in_acc && (act == gad_pkg::ACT_LOAD_DEC)),
		.waddr  (s_axis_tdata[7:0]),
		.wdata  (s_axis_tdata[15:8]),
		.raddr  (s_axis_tdata[7:0]),
		.rdata  (dec_rdata)
	);

	gad_lut u_enc (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (in_acc && (act == gad_pkg::ACT_LOAD_ENC)),
		.waddr  (s_axis_tdata[7:0]),
		.wdata  (s_axis_tdata[15:8]),
		.raddr  (qres.recon),
		.rdata  (enc_rdata)
	);

	assign line_raddr = sof ? '0 : column_q;

	gad_err_mem #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (lw_we),
		.waddr  (lw_addr),
		.wdata  (lw_data),
		.raddr  (line_raddr),
		.rdata  (line_rdata)
	);

	assign q_start = (state_q == ST_LOOK);

	gad_quant u_quant (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (q_start),
		.s      (s_clamp),
		.bits   (bits_eff),
		.done   (q_done),
		.res    (qres)
	);

	// incoming error and clamped linear value
	always_comb begin
		inc    = first_row_q ? right_q : sat_err(ext(right_q) + ext(line_rdata));
		s_full = $signed({6'b0, dec_rdata, 8'b0}) + ext(inc);
		if (s_full < 0) begin
			s_clamp = 16'd0;
		end else if (s_full > 22'sd65280) begin
			s_clamp = 16'(gad_pkg::FULL_Q8);
		end else begin
			s_clamp = s_full[15:0];
		end
	end

	// quantization error and its shares
	always_comb begin
		sum_x  = $signed({6'b0, pix_q, 8'b0}) + ext(inc_q) - $signed({6'b0, qres.q});
		err    = sat_err(sum_x);
		err_x  = ext(err);
		e3_q16 = div16(err_x + (err_x <<< 1));
		e5_q16 = div16(err_x + (err_x <<< 2));
		e7_q16 = div16((err_x <<< 3) - err_x);
		e1_q16 = div16(err_x);
		wr_cm1 = sat_err(ext(bp0_q) + e3_q16);
		p0     = sat_err(ext(bp1_q) + e5_q16);
	end

	assign lw_we   = ((state_q == ST_ERR) && (column_q != '0)) || (state_q == ST_LASTW);
	assign lw_addr = (state_q == ST_LASTW) ? column_q : (column_q - CW'(1));
	assign lw_data = (state_q == ST_LASTW) ? p0_q : wr_cm1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= 4'd1;
			width_q <= 11'd1024;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				gad_pkg::REG_BITS:  bits_q  <= cfg_data[3:0];
				gad_pkg::REG_WIDTH: width_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			column_q    <= '0;
			right_q     <= '0;
			bp0_q       <= '0;
			bp1_q       <= '0;
			first_row_q <= 1'b1;
			m_tvalid_q  <= 1'b0;
		end else begin
			// the output step reloads the register itself
			if (m_tvalid_q && m_axis_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (act == gad_pkg::ACT_PIXEL)) begin
						if (sof) begin
							column_q    <= '0;
							right_q     <= '0;
							bp0_q       <= '0;
							bp1_q       <= '0;
							first_row_q <= 1'b1;
						end
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_QUANT;
				end
				ST_QUANT: begin
					if (q_done) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					if (last) begin
						state_q <= ST_LASTW;
					end else begin
						bp0_q    <= p0;
						bp1_q    <= e1_q16[gad_pkg::ERR_W-1:0];
						right_q  <= e7_q16[gad_pkg::ERR_W-1:0];
						column_q <= column_q + CW'(1);
						state_q  <= ST_OUT;
					end
				end
				ST_LASTW: begin
					bp0_q       <= '0;
					bp1_q       <= '0;
					right_q     <= '0;
					column_q    <= '0;
					first_row_q <= 1'b0;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_axis_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_q <= s_axis_tdata[7:0];
		end
		if (state_q == ST_LOOK) begin
			inc_q <= inc;
		end
		if (state_q == ST_ERR) begin
			res_po_q  <= enc_rdata;
			res_lvl_q <= qres.level;
			p0_q      <= p0;
		end
		if ((state_q == ST_OUT) && (!m_tvalid_q || m_axis_tready)) begin
			m_tdata_q <= {res_lvl_q, res_po_q};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	// line memory is written only by the error steps of a pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		lw_we |-> ((state_q == ST_ERR) || (state_q == ST_LASTW)))
	else $error("line memory write outside error steps");

	// quantizer finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		q_done |-> (state_q == ST_QUANT))
	else $error("quantizer result with no pixel waiting");

	// a finished result waits while the output register is still full
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && m_tvalid_q && !m_axis_tready) |=> (state_q == ST_OUT))
	else $error("result dropped over a stalled output");

	// an accepted pixel starts the lookup step on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (act == gad_pkg::ACT_PIXEL)) |=> (state_q == ST_LOOK))
	else $error("accepted pixel not started");

	// the column pointer returns to the row start after the last pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LASTW) |=> (column_q == '0))
	else $error("column not rewound at row end");

endmodule

// ===== rtl/gad_lut.sv =====
// gad_lut: 256 x 8 loadable lookup memory with a registered read
// entries never loaded read back their own address; no package use
`timescale 1ns / 1ps

module gad_lut (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       we,
	input  logic [7:0] waddr,
	input  logic [7:0] wdata,
	input  logic [7:0] raddr,
	output logic [7:0] rdata
);

	logic [7:0]   mem [256];
	logic [255:0] valid_q;
	logic [7:0]   data_s1;
	logic [7:0]   addr_s1;
	logic         hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		data_s1 <= mem[raddr];
		addr_s1 <= raddr;
		hit_s1  <= valid_q[raddr];
	end

	// identity mapping until the entry is loaded
	assign rdata = hit_s1 ? data_s1 : addr_s1;

endmodule

// ===== rtl/gad_err_mem.sv =====
// gad_err_mem: next-row error line memory, one write and one read port
// depends on gad_pkg for the error word type; reads beyond the fill mark give zero
`timescale 1ns / 1ps

module gad_err_mem #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         we,
	input  logic [$clog2(MAX_WIDTH)-1:0] waddr,
	input  gad_pkg::err_t                wdata,
	input  logic [$clog2(MAX_WIDTH)-1:0] raddr,
	output gad_pkg::err_t                rdata
);

	localparam int FW = $clog2(MAX_WIDTH + 1);

	gad_pkg::err_t mem [MAX_WIDTH];
	logic [FW-1:0] fill_q;
	gad_pkg::err_t data_s1;
	logic          hit_s1;

	// rows always write a prefix from column 0, so one mark tracks what was written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (we && (FW'(waddr) >= fill_q)) begin
			fill_q <= FW'(waddr) + FW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		data_s1 <= mem[raddr];
		hit_s1  <= (FW'(raddr) < fill_q);
	end

	assign rdata = hit_s1 ? data_s1 : gad_pkg::err_t'(0);

endmodule

// ===== rtl/gad_quant.sv =====
// gad_quant: five-stage quantizer from clamped value to level, recon and q
// depends on gad_pkg (quant_res_t, HALF_Q8)
`timescale 1ns / 1ps

module gad_quant (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [15:0]         s,
	input  logic [3:0]          bits,
	output logic                done,
	output gad_pkg::quant_res_t res
);

	// floor(2^31 / (2^bits - 1))
	function automatic logic [31:0] recip(input logic [3:0] b);
		logic [31:0] r;
		case (b)
			4'd2:    r = 32'd715827882;
			4'd3:    r = 32'd306783378;
			4'd4:    r = 32'd143165576;
			4'd5:    r = 32'd69273666;
			4'd6:    r = 32'd34087042;
			4'd7:    r = 32'd16909320;
			4'd8:    r = 32'd8421504;
			default: r = 32'h8000_0000;
		endcase
		return r;
	endfunction

	// floor(y / 255) for y below 65280
	function automatic logic [7:0] div255(input logic [16:0] y);
		logic [17:0] z;
		z = 18'(y) + 18'(y >> 8) + 18'd1;
		return z[15:8];
	endfunction

	logic [7:0]  maxv;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [23:0] prod_s1;
	logic [7:0]  m_s1, m_s2, m_s3, m_s4;
	logic [31:0] rb_s1, rb_s2;
	logic [7:0]  lvl_s2, lvl_s3, lvl_s4;
	logic [15:0] qe_s3, qe_s4;
	logic [23:0] x_s3;
	logic [8:0]  rem_s4;

	logic [16:0] y;
	logic [15:0] t;
	logic [47:0] prodr;
	logic [23:0] prodm;
	logic [24:0] rem_full;
	logic [15:0] qfix;
	logic [8:0]  rfix;
	logic        round_up;

	assign maxv = 8'((9'd1 << bits) - 9'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// level = floor((s*max + 32640) / 65280), split as /256 then /255
	assign y = 17'((25'(prod_s1) + 25'(gad_pkg::HALF_Q8)) >> 8);

	// 256*level*255 / max through the reciprocal, low by at most one
	assign t     = 16'({lvl_s2, 8'b0} - {8'b0, lvl_s2});
	assign prodr = 48'(t) * 48'(rb_s2);

	assign prodm    = 24'(qe_s3) * 24'(m_s3);
	assign rem_full = 25'(x_s3) - 25'(prodm);

	always_comb begin
		if (rem_s4 >= {1'b0, m_s4}) begin
			qfix = qe_s4 + 16'd1;
			rfix = rem_s4 - {1'b0, m_s4};
		end else begin
			qfix = qe_s4;
			rfix = rem_s4;
		end
		round_up = ({rfix, 1'b0} >= {2'b0, m_s4});
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= 24'(s) * 24'(maxv);
			m_s1    <= maxv;
			rb_s1   <= recip(bits);
		end
		if (v_s1) begin
			lvl_s2 <= div255(y);
			m_s2   <= m_s1;
			rb_s2  <= rb_s1;
		end
		if (v_s2) begin
			qe_s3  <= prodr[38:23];
			x_s3   <= {t, 8'b0};
			m_s3   <= m_s2;
			lvl_s3 <= lvl_s2;
		end
		if (v_s3) begin
			qe_s4  <= qe_s3;
			rem_s4 <= rem_full[8:0];
			m_s4   <= m_s3;
			lvl_s4 <= lvl_s3;
		end
		if (v_s4) begin
			res.level <= lvl_s4;
			res.recon <= qfix[15:8];
			res.q     <= qfix + {15'b0, round_up};
		end
	end

	assign done = v_s5;

endmodule

// ===== tb/gamma_aware_error_diffusion_dither_unit_tb.sv =====
// gamma_aware_error_diffusion_dither_unit_tb: self-checking bench for the gray dither unit
// predicts every dithered pixel in-bench and compares it under random idling and stalls
// depends on gad_pkg and gamma_aware_error_diffusion_dither_unit
`timescale 1ns / 1ps

module gamma_aware_error_diffusion_dither_unit_tb;

	localparam int         LINE_MAX       = 1024;
	localparam logic [1:0] ACT_NONE       = 2'd3;
	localparam int         SETTLE_CYCLES  = 16;
	localparam int         RX_HOLD_CYCLES = 400;
	localparam int         CYCLE_LIMIT    = 1000000;
	localparam int         REPORT_MAX     = 10;

	typedef struct {
		logic [7:0] pix_out;
		logic [7:0] lvl;
	} dithered_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;  // pixel, table_value
	logic [2:0]  s_axis_tuser  = '0;  // action, start_of_frame
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // pixel_out, level
	logic        cfg_we        = 1'b0;
	logic        cfg_addr      = 1'b0;
	logic [10:0] cfg_data      = '0;

	// dither state as the block should hold it
	int unsigned cur_bits  = 1;
	int unsigned cur_width = 1024;
	int          line_err [LINE_MAX];
	int          right_err = 0;
	int          pend_lo   = 0;
	int          pend_hi   = 0;
	int unsigned col       = 0;
	bit          top_row   = 1'b1;
	logic [7:0]  dec_lut [256];
	logic [7:0]  enc_lut [256];
	dithered_t   owed_px [$];

	int          tx_idle_pct    = 0;
	int          rx_stall_pct   = 0;
	logic        rx_hold        = 1'b0;
	event        rx_hold_ev;
	int          mismatch_count = 0;
	int unsigned cycle_count    = 0;

	gamma_aware_error_diffusion_dither_unit #(.MAX_WIDTH(LINE_MAX)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int clip_err(int v);
		if (v > gad_pkg::ERR_LIM) return gad_pkg::ERR_LIM;
		if (v < -gad_pkg::ERR_LIM) return -gad_pkg::ERR_LIM;
		return v;
	endfunction

	function automatic void dither_pixel(logic [7:0] pix, logic sof);
		int unsigned nbits, maxv, w, c, lvl, recon, qv;
		int incoming, s, err, p0;
		bit row_end;
		dithered_t res;
		if (sof) begin
			right_err = 0;
			pend_lo = 0;
			pend_hi = 0;
			col = 0;
			top_row = 1'b1;
		end
		nbits = (cur_bits < 1) ? 1 : (cur_bits > 8) ? 8 : cur_bits;
		maxv = (1 << nbits) - 1;
		w = (cur_width < 1) ? 1 : (cur_width > LINE_MAX) ? LINE_MAX : cur_width;
		c = (col >= LINE_MAX) ? LINE_MAX - 1 : col;
		row_end = (c + 1 >= w);
		incoming = right_err;
		if (!top_row) incoming = clip_err(incoming + line_err[c]);
		s = int'(dec_lut[pix]) * 256 + incoming;
		if (s < 0) s = 0;
		if (s > gad_pkg::FULL_Q8) s = gad_pkg::FULL_Q8;
		// round half up onto the level grid, then back to 8 bits and to Q.8
		lvl = (2 * unsigned'(s) * maxv + gad_pkg::FULL_Q8) / (2 * gad_pkg::FULL_Q8);
		recon = lvl * 255 / maxv;
		qv = (2 * lvl * gad_pkg::FULL_Q8 + maxv) / (2 * maxv);
		// error taken against the raw pixel, not the decoded one
		err = clip_err(int'(pix) * 256 + incoming - int'(qv));
		if (c > 0) line_err[c - 1] = clip_err(pend_lo + err * 3 / 16);
		p0 = clip_err(pend_hi + err * 5 / 16);
		if (row_end) begin
			line_err[c] = p0;
			pend_lo = 0;
			pend_hi = 0;
			right_err = 0;
			col = 0;
			top_row = 1'b0;
		end else begin
			pend_lo = p0;
			pend_hi = err / 16;
			right_err = err * 7 / 16;
			col = c + 1;
		end
		res.pix_out = enc_lut[recon[7:0]];
		res.lvl = lvl[7:0];
		owed_px.push_back(res);
	endfunction

	task automatic note_mismatch(string what, logic [7:0] want, logic [7:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("mismatch at %0t ns: %s expected %h got %h", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		dithered_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (owed_px.size() == 0) begin
				note_mismatch("result with nothing owed, pixel_out", 8'hxx, m_axis_tdata[7:0]);
			end else begin
				want = owed_px.pop_front();
				if (m_axis_tdata[7:0] !== want.pix_out)
					note_mismatch("pixel_out", want.pix_out, m_axis_tdata[7:0]);
				if (m_axis_tdata[15:8] !== want.lvl)
					note_mismatch("level", want.lvl, m_axis_tdata[15:8]);
			end
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
	end

	// long receiver hold so the block backs up into its input
	always begin
		@(rx_hold_ev);
		rx_hold <= 1'b1;
		repeat (RX_HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// valid stays up after the transfer; the next call or settle decides
	task automatic send_item(logic [1:0] act, logic [7:0] pix, logic [7:0] tval, logic sof);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {tval, pix};
		s_axis_tuser <= {sof, act};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		case (act)
			gad_pkg::ACT_LOAD_DEC: dec_lut[pix] = tval;
			gad_pkg::ACT_LOAD_ENC: enc_lut[pix] = tval;
			gad_pkg::ACT_PIXEL:    dither_pixel(pix, sof);
			default: ;
		endcase
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (owed_px.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val[10:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == gad_pkg::REG_BITS) cur_bits = val & 4'hF;
		else cur_width = val & 11'h7FF;
	endtask

	task automatic test_pixel_extremes();
		send_item(gad_pkg::ACT_PIXEL, 8'd0, 8'd0, 1'b1);
		send_item(gad_pkg::ACT_PIXEL, 8'd255, 8'hFF, 1'b0);
		send_item(gad_pkg::ACT_PIXEL, 8'd128, 8'h55, 1'b0);
		// unknown action with start of frame set must not touch the position
		send_item(ACT_NONE, 8'd200, 8'hAA, 1'b1);
		send_item(gad_pkg::ACT_PIXEL, 8'd1, 8'd0, 1'b0);
		send_item(gad_pkg::ACT_PIXEL, 8'd254, 8'd0, 1'b0);
		settle();
	endtask

	task automatic test_table_loads();
		send_item(gad_pkg::ACT_LOAD_DEC, 8'd255, 8'd0, 1'b1);
		send_item(gad_pkg::ACT_LOAD_DEC, 8'd0, 8'd255, 1'b0);
		send_item(gad_pkg::ACT_LOAD_ENC, 8'd0, 8'd255, 1'b1);
		send_item(gad_pkg::ACT_LOAD_ENC, 8'd255, 8'd0, 1'b0);
		send_item(gad_pkg::ACT_PIXEL, 8'd255, 8'd0, 1'b0);
		send_item(gad_pkg::ACT_PIXEL, 8'd0, 8'd0, 1'b0);
		settle();
	endtask

	task automatic test_register_extremes();
		write_reg(gad_pkg::REG_BITS, 0);
		write_reg(gad_pkg::REG_WIDTH, 0);
		send_item(gad_pkg::ACT_PIXEL, 8'd100, 8'd0, 1'b1);
		send_item(gad_pkg::ACT_PIXEL, 8'd160, 8'd0, 1'b0);
		settle();
		write_reg(gad_pkg::REG_BITS, 15);
		write_reg(gad_pkg::REG_WIDTH, 2047);
		send_item(gad_pkg::ACT_PIXEL, 8'd200, 8'd0, 1'b1);
		send_item(gad_pkg::ACT_PIXEL, 8'd37, 8'd0, 1'b0);
		settle();
		write_reg(gad_pkg::REG_BITS, 8);
		write_reg(gad_pkg::REG_WIDTH, 1);
		send_item(gad_pkg::ACT_PIXEL, 8'd90, 8'd0, 1'b1);
		send_item(gad_pkg::ACT_PIXEL, 8'd91, 8'd0, 1'b0);
		settle();
	endtask

	task automatic test_row_edges();
		write_reg(gad_pkg::REG_BITS, 2);
		write_reg(gad_pkg::REG_WIDTH, 3);
		send_item(gad_pkg::ACT_PIXEL, 8'd70, 8'd0, 1'b1);
		send_item(gad_pkg::ACT_PIXEL, 8'd140, 8'd0, 1'b0);
		send_item(gad_pkg::ACT_PIXEL, 8'd210, 8'd0, 1'b0);
		send_item(gad_pkg::ACT_PIXEL, 8'd33, 8'd0, 1'b0);
		settle();
		// wider second row reads line entries the first row never wrote
		write_reg(gad_pkg::REG_WIDTH, 6);
		repeat (3) send_item(gad_pkg::ACT_PIXEL, 8'($urandom_range(255)), 8'd0, 1'b0);
		settle();
		// shrinking below the current column ends the row at once
		write_reg(gad_pkg::REG_WIDTH, 2);
		send_item(gad_pkg::ACT_PIXEL, 8'd180, 8'd0, 1'b0);
		send_item(gad_pkg::ACT_PIXEL, 8'd60, 8'd0, 1'b0);
		settle();
	endtask

	task automatic test_backpressure();
		-> rx_hold_ev;
		send_item(gad_pkg::ACT_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
		repeat (39) send_item(gad_pkg::ACT_PIXEL, 8'($urandom_range(255)),
			8'($urandom_range(255)), 1'b0);
		settle();
	endtask

	task automatic test_random_stream(int unsigned n_items);
		int unsigned sent, frame_len, roll, span;
		logic sof_pending;
		sent = 0;
		while (sent < n_items) begin
			settle();
			roll = $urandom_range(99);
			if (roll < 70)
				write_reg(gad_pkg::REG_BITS,
					(roll < 8) ? $urandom_range(15) : $urandom_range(1, 8));
			roll = $urandom_range(99);
			if (roll < 3) write_reg(gad_pkg::REG_WIDTH, $urandom_range(1025, 2047));
			else if (roll < 6) write_reg(gad_pkg::REG_WIDTH, LINE_MAX);
			else if (roll < 8) write_reg(gad_pkg::REG_WIDTH, 0);
			else if (roll < 75) write_reg(gad_pkg::REG_WIDTH, $urandom_range(1, 24));
			span = (cur_width == 0) ? 1 : (cur_width > LINE_MAX) ? LINE_MAX : cur_width;
			frame_len = $urandom_range(1, (3 * span < 120) ? 3 * span : 120);
			// most frames restart, the rest carry on under the new settings
			sof_pending = ($urandom_range(99) < 80);
			repeat (frame_len) begin
				roll = $urandom_range(99);
				if (roll < 4) begin
					send_item(gad_pkg::ACT_LOAD_DEC, 8'($urandom_range(255)),
						8'($urandom_range(255)), 1'($urandom_range(1)));
				end else if (roll < 7) begin
					send_item(gad_pkg::ACT_LOAD_ENC, 8'($urandom_range(255)),
						8'($urandom_range(255)), 1'($urandom_range(1)));
				end else if (roll < 9) begin
					send_item(ACT_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)),
						1'($urandom_range(1)));
				end else begin
					send_item(gad_pkg::ACT_PIXEL, 8'($urandom_range(255)),
						8'($urandom_range(255)),
						sof_pending || ($urandom_range(199) == 0));
					sof_pending = 1'b0;
				end
			end
			sent += frame_len;
		end
	endtask

	initial begin
		for (int i = 0; i < 256; i++) begin
			dec_lut[i] = 8'(i);
			enc_lut[i] = 8'(i);
		end
		for (int i = 0; i < LINE_MAX; i++) line_err[i] = 0;
		tx_idle_pct = 32;
		rx_stall_pct = 59;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pixel_extremes();
		test_table_loads();
		test_register_extremes();
		test_row_edges();
		test_random_stream(560);
		tx_idle_pct = 59;
		rx_stall_pct = 32;
		test_random_stream(560);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		test_backpressure();
		test_random_stream(560);
		settle();
		if (mismatch_count == 0 && owed_px.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
